FILE: hw/rtl/kbd_diff_pkg.sv
// ----------------------------------------------------------------------------
// kbd_diff_pkg
// Types and constants shared by the keyboard report differencer.
// ----------------------------------------------------------------------------
package kbd_diff_pkg;

   localparam int KEY_SLOTS     = 6;
   localparam int MOD_BITS      = 8;
   localparam int CODE_W        = 8;
   localparam int MOD_CODE_BASE = 224;
   localparam int EVT_HALF      = MOD_BITS + KEY_SLOTS;
   localparam int EVT_COUNT     = 2 * EVT_HALF;

   typedef logic [CODE_W-1:0] code_type;
   typedef logic [KEY_SLOTS-1:0][CODE_W-1:0] key_array_type;

   typedef struct packed {
      logic [7:0] modifier_bits;
      logic [7:0] key_slot0;
      logic [7:0] key_slot1;
      logic [7:0] key_slot2;
      logic [7:0] key_slot3;
      logic [7:0] key_slot4;
      logic [7:0] key_slot5;
   } req_type;

   typedef struct packed {
      logic [7:0] event_code;
      logic       is_press;
      logic       last_event;
   } rsp_type;

   // one report's worth of pending events, in emission order from bit 0
   typedef struct packed {
      logic                                load;
      logic [EVT_COUNT-1:0]                mask;
      logic [EVT_COUNT-1:0][CODE_W-1:0]    codes;
   } evt_batch_type;

endpackage

FILE: hw/rtl/kbd_diff_lane.sv
// ----------------------------------------------------------------------------
// kbd_diff_lane
// Flags one key slot whose nonzero code is absent from the other report.
// ----------------------------------------------------------------------------
module kbd_diff_lane (
   input  kbd_diff_pkg::code_type      slot_code,
   input  kbd_diff_pkg::key_array_type other_keys,
   output logic                        changed
);
   import kbd_diff_pkg::*;

   logic present;

   always_comb begin
      present = 1'b0;
      for (int i = 0; i < KEY_SLOTS; i++) begin
         if (other_keys[i] == slot_code) begin
            present = 1'b1;
         end
      end
      changed = (slot_code != '0) && !present;
   end

endmodule

FILE: hw/rtl/kbd_diff_merge.sv
// ----------------------------------------------------------------------------
// kbd_diff_merge
// Holds a report's event flags and sends them out one beat per cycle, while
// the output is not stalled, lowest flag first, through an output register.
// ----------------------------------------------------------------------------
module kbd_diff_merge (
   input  logic                        clock,
   input  logic                        reset,
   input  kbd_diff_pkg::evt_batch_type batch,
   output logic                        can_load,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output kbd_diff_pkg::rsp_type       rsp_data
);
   import kbd_diff_pkg::*;

   logic [EVT_COUNT-1:0]             pend_ff, pend_in;
   logic [EVT_COUNT-1:0][CODE_W-1:0] codes_ff, codes_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   rsp_type                          rsp_data_ff, rsp_data_in;

   logic [EVT_COUNT-1:0] pick;
   logic [EVT_COUNT-1:0] rest;
   logic                 out_free;
   logic                 fire;
   code_type             sel_code;

   always_comb begin
      pick     = pend_ff & (~pend_ff + 1'b1);
      rest     = pend_ff & ~pick;
      out_free = !rsp_valid_ff || !rsp_stall;
      fire     = out_free && (pend_ff != '0);
      can_load = (pend_ff == '0) || (fire && (rest == '0));

      sel_code = '0;
      for (int i = 0; i < EVT_COUNT; i++) begin
         sel_code = sel_code | (codes_ff[i] & {CODE_W{pick[i]}});
      end

      if (batch.load) begin
         pend_in  = batch.mask;
         codes_in = batch.codes;
      end else begin
         pend_in  = fire ? rest : pend_ff;
         codes_in = codes_ff;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (fire) begin
         rsp_valid_in           = 1'b1;
         rsp_data_in.event_code = sel_code;
         rsp_data_in.is_press   = |pick[EVT_HALF-1:0];
         rsp_data_in.last_event = (rest == '0);
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      codes_ff    <= codes_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: hw/rtl/keyboard_report_diff_events_top.sv
// ----------------------------------------------------------------------------
// keyboard_report_diff_events_top
// Boot keyboard report differencer: turns each report into key press and
// release events against the previously accepted report.
//
// req_ channel: one beat per report, a modifier byte and six key codes.
// rsp_ channel: one beat per event, presses first (modifiers in bit order
// as codes 224 to 231, then new keys in slot order), then releases found the
// same way; last_event marks the final beat of a report. A report with no
// change gives no beats.
// The first event of a report passes the pending-flag register and then
// the shared output register. Events leave one per cycle unless rsp_ is
// stalled; req_ is held while a report's events wait, and the next report
// is taken in the cycle its predecessor's last event is loaded, so reports
// follow back to back. Six slot lanes per direction compare all codes.
// Reset clears the stored report to all zero and drops pending events.
// A stall on rsp_ holds the output beat and, while events are pending,
// stalls req_.
// ----------------------------------------------------------------------------
module keyboard_report_diff_events_top (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  kbd_diff_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output kbd_diff_pkg::rsp_type rsp_data
);
   import kbd_diff_pkg::*;

   logic [MOD_BITS-1:0] old_mods_ff, old_mods_in;
   key_array_type       old_keys_ff, old_keys_in;

   key_array_type       new_keys;
   logic [KEY_SLOTS-1:0] press_hit;
   logic [KEY_SLOTS-1:0] release_hit;
   logic                can_load;
   logic                accept;
   evt_batch_type       batch;

   assign new_keys[0] = req_data.key_slot0;
   assign new_keys[1] = req_data.key_slot1;
   assign new_keys[2] = req_data.key_slot2;
   assign new_keys[3] = req_data.key_slot3;
   assign new_keys[4] = req_data.key_slot4;
   assign new_keys[5] = req_data.key_slot5;

   for (genvar g = 0; g < KEY_SLOTS; g++) begin : g_lane
      kbd_diff_lane u_press (
         .slot_code (new_keys[g]),
         .other_keys(old_keys_ff),
         .changed   (press_hit[g])
      );
      kbd_diff_lane u_release (
         .slot_code (old_keys_ff[g]),
         .other_keys(new_keys),
         .changed   (release_hit[g])
      );
   end

   assign accept    = req_valid && can_load;
   assign req_stall = !can_load;

   always_comb begin
      batch.load = accept;
      batch.mask = {release_hit,
                    old_mods_ff & ~req_data.modifier_bits,
                    press_hit,
                    req_data.modifier_bits & ~old_mods_ff};
      for (int b = 0; b < MOD_BITS; b++) begin
         batch.codes[b]            = code_type'(MOD_CODE_BASE + b);
         batch.codes[EVT_HALF + b] = code_type'(MOD_CODE_BASE + b);
      end
      for (int i = 0; i < KEY_SLOTS; i++) begin
         batch.codes[MOD_BITS + i]            = new_keys[i];
         batch.codes[EVT_HALF + MOD_BITS + i] = old_keys_ff[i];
      end

      old_mods_in = accept ? req_data.modifier_bits : old_mods_ff;
      old_keys_in = accept ? new_keys : old_keys_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         old_mods_ff <= '0;
         old_keys_ff <= '0;
      end else begin
         old_mods_ff <= old_mods_in;
         old_keys_ff <= old_keys_in;
      end
   end

   kbd_diff_merge u_merge (
      .clock    (clock),
      .reset    (reset),
      .batch    (batch),
      .can_load (can_load),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

endmodule
